// ----- design/udp_socket_demux_table_defines.svh -----
// Assertion macros for the UDP socket demux table checker
`ifndef UDP_SOCKET_DEMUX_TABLE_DEFINES_SVH
`define UDP_SOCKET_DEMUX_TABLE_DEFINES_SVH

// checked only out of reset
`define UDST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define UDST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/udst_pkg.sv -----
// Shared types and constants for the UDP socket demux table
package udst_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_ALLOC  = 2'd2;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_MISS   = 2'd1;
  localparam logic [1:0] STAT_NOPORT = 2'd2;

  localparam logic [15:0] DYN_FIRST_RST = 16'd1024;
  localparam logic [15:0] DYN_LIMIT_RST = 16'd65535;

  localparam logic CFG_IDX_FIRST = 1'b0;
  localparam logic CFG_IDX_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_ALLOC,
    S_RESP
  } state_t;

  // token moving down the cell chain; lookup or port probe
  typedef struct packed {
    logic              vld;
    logic              lookup;
    logic [31:0]       sip;
    logic [15:0]       sport;
    logic [31:0]       dip;
    logic [15:0]       dport;   // probe: candidate port
    logic              match;   // probe: port in use
    logic [SLOT_W-1:0] idx;
  } tok_t;

  // slot update broadcast to all cells
  typedef struct packed {
    logic              we;      // full slot write
    logic              pwe;     // local port only
    logic [SLOT_W-1:0] sel;
    logic              valid;
    logic [31:0]       lip;
    logic [15:0]       lport;
    logic [31:0]       rip;
    logic [15:0]       rport;
  } slot_wr_t;

endpackage

// ----- design/udst_cell.sv -----
// One socket slot of the table plus its stage of the match chain
module udst_cell
  import udst_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SLOT_W-1:0] cell_idx,
  input  logic              kill,
  input  slot_wr_t          wr_i,
  input  tok_t              tok_i,
  output tok_t              tok_o
);

  logic        valid_r;
  logic [31:0] lip_r;
  logic [15:0] lport_r;
  logic [31:0] rip_r;
  logic [15:0] rport_r;
  tok_t        tok_r;
  tok_t        tok_nxt;
  logic        hit;

  always_comb begin
    hit = valid_r && (tok_i.dport != 16'd0) && (lport_r == tok_i.dport) &&
          ((lip_r == 32'd0) || (lip_r == tok_i.dip)) &&
          ((rip_r == 32'd0) || (rip_r == tok_i.sip)) &&
          ((rport_r == 16'd0) || (rport_r == tok_i.sport));
    tok_nxt = tok_i;
    if (tok_i.lookup) begin
      if (hit && !tok_i.match) begin
        tok_nxt.match = 1'b1;
        tok_nxt.idx   = cell_idx;
      end
    end else if (valid_r && (lport_r == tok_i.dport)) begin
      tok_nxt.match = 1'b1;
    end
  end

  // valid bits reset; token payload and slot fields load without reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_nxt.vld && !kill;
      if (wr_i.we && (wr_i.sel == cell_idx)) begin
        valid_r <= wr_i.valid;
      end
    end
    tok_r.lookup <= tok_nxt.lookup;
    tok_r.sip    <= tok_nxt.sip;
    tok_r.sport  <= tok_nxt.sport;
    tok_r.dip    <= tok_nxt.dip;
    tok_r.dport  <= tok_nxt.dport;
    tok_r.match  <= tok_nxt.match;
    tok_r.idx    <= tok_nxt.idx;
    if (wr_i.we && (wr_i.sel == cell_idx)) begin
      lip_r   <= wr_i.lip;
      lport_r <= wr_i.lport;
      rip_r   <= wr_i.rip;
      rport_r <= wr_i.rport;
    end else if (wr_i.pwe && (wr_i.sel == cell_idx)) begin
      lport_r <= wr_i.lport;
    end
  end

  assign tok_o = tok_r;

endmodule

// ----- design/udp_socket_demux_table.sv -----
// Lookup: the token runs through the 16-cell match chain, then S_RESP registers
// the result. Slot write or rejected request: S_RESP registers the result directly.
// Allocation: candidate ports enter the chain one per cycle; then S_RESP registers it.
// One request is worked at a time; the next is taken once the result is registered.
// Reset (sync, rst_n low): all slots invalid, dyn first 1024, limit 65535 (ports 1024..65534), pointer 1024.
module udp_socket_demux_table
  import udst_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // request stream
  input  logic         in_tvalid,
  output logic         in_tready,
  // slot[3:0], entry_valid[4], entry_local_ip[36:5], entry_local_port[52:37],
  // entry_remote_ip[84:53], entry_remote_port[100:85], pkt_src_ip[132:101],
  // pkt_src_port[148:133], pkt_dst_ip[180:149], pkt_dst_port[196:181], zero fill
  input  logic [199:0] in_tdata,
  input  logic [1:0]   in_tuser,   // req_type[1:0]
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [23:0]  out_tdata,  // hit_slot[3:0], port_out[19:4], zero fill
  output logic [1:0]   out_tuser,  // status[1:0]
  // config
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [3:0]  f_slot;
  logic        f_entry_valid;
  logic [31:0] f_local_ip;
  logic [15:0] f_local_port;
  logic [31:0] f_remote_ip;
  logic [15:0] f_remote_port;
  logic [31:0] f_src_ip;
  logic [15:0] f_src_port;
  logic [31:0] f_dst_ip;
  logic [15:0] f_dst_port;

  assign f_slot        = in_tdata[3:0];
  assign f_entry_valid = in_tdata[4];
  assign f_local_ip    = in_tdata[36:5];
  assign f_local_port  = in_tdata[52:37];
  assign f_remote_ip   = in_tdata[84:53];
  assign f_remote_port = in_tdata[100:85];
  assign f_src_ip      = in_tdata[132:101];
  assign f_src_port    = in_tdata[148:133];
  assign f_dst_ip      = in_tdata[180:149];
  assign f_dst_port    = in_tdata[196:181];

  // config registers
  logic [15:0] dyn_first_r;
  logic [15:0] dyn_limit_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = {16'd0, (cfg_paddr[2] == CFG_IDX_LIMIT) ? dyn_limit_r : dyn_first_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dyn_first_r <= DYN_FIRST_RST;
      dyn_limit_r <= DYN_LIMIT_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == CFG_IDX_FIRST) begin
        dyn_first_r <= cfg_pwdata[15:0];
      end else begin
        dyn_limit_r <= cfg_pwdata[15:0];
      end
    end
  end

  // cell chain
  tok_t     tok [SLOTS+1];
  tok_t     issue_tok;
  tok_t     exit_tok;
  slot_wr_t wr;
  logic     kill;

  assign tok[0]   = issue_tok;
  assign exit_tok = tok[SLOTS];

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    udst_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (SLOT_W'(k)),
      .kill     (kill),
      .wr_i     (wr),
      .tok_i    (tok[k]),
      .tok_o    (tok[k+1])
    );
  end

  function automatic logic [15:0] port_norm(input logic [15:0] c, input logic [15:0] first,
                                            input logic [15:0] limit);
    return ((c < first) || (c >= limit)) ? first : c;
  endfunction

  function automatic logic [15:0] port_succ(input logic [15:0] c, input logic [15:0] first,
                                            input logic [15:0] limit);
    logic [16:0] n;
    n = {1'b0, c} + 17'd1;
    return (n >= {1'b0, limit}) ? first : n[15:0];
  endfunction

  // control
  state_t            state_r, state_nxt;
  logic [15:0]       next_port_r, next_port_nxt;
  logic [15:0]       cand_r, cand_nxt;
  logic [15:0]       issued_r, issued_nxt;
  logic [15:0]       ret_r, ret_nxt;
  logic [SLOT_W-1:0] sel_r, sel_nxt;
  logic [1:0]        res_stat_r, res_stat_nxt;
  logic [3:0]        res_hit_r, res_hit_nxt;
  logic [15:0]       res_port_r, res_port_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_stat_r, out_stat_nxt;
  logic [3:0]        out_hit_r, out_hit_nxt;
  logic [15:0]       out_port_r, out_port_nxt;
  logic              slot_ok;
  logic [15:0]       tries;
  logic [15:0]       cand_c;

  assign slot_ok = {1'b0, f_slot} < 5'(SLOTS);
  assign tries   = dyn_limit_r - dyn_first_r;
  assign cand_c  = port_norm(cand_r, dyn_first_r, dyn_limit_r);

  always_comb begin
    state_nxt     = state_r;
    next_port_nxt = next_port_r;
    cand_nxt      = cand_r;
    issued_nxt    = issued_r;
    ret_nxt       = ret_r;
    sel_nxt       = sel_r;
    res_stat_nxt  = res_stat_r;
    res_hit_nxt   = res_hit_r;
    res_port_nxt  = res_port_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_stat_nxt  = out_stat_r;
    out_hit_nxt   = out_hit_r;
    out_port_nxt  = out_port_r;
    issue_tok     = '0;
    wr            = '0;
    kill          = 1'b0;
    in_tready     = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          res_stat_nxt = STAT_OK;
          res_hit_nxt  = 4'd0;
          res_port_nxt = 16'd0;
          state_nxt    = S_RESP;
          case (in_tuser)
            REQ_WRITE: begin
              wr.we    = slot_ok;
              wr.sel   = SLOT_W'(f_slot);
              wr.valid = f_entry_valid;
              wr.lip   = f_local_ip;
              wr.lport = f_local_port;
              wr.rip   = f_remote_ip;
              wr.rport = f_remote_port;
            end
            REQ_LOOKUP: begin
              issue_tok.vld    = 1'b1;
              issue_tok.lookup = 1'b1;
              issue_tok.sip    = f_src_ip;
              issue_tok.sport  = f_src_port;
              issue_tok.dip    = f_dst_ip;
              issue_tok.dport  = f_dst_port;
              state_nxt        = S_LOOK;
            end
            REQ_ALLOC: begin
              if (slot_ok && (dyn_limit_r > dyn_first_r)) begin
                cand_nxt   = next_port_r;
                issued_nxt = 16'd0;
                ret_nxt    = 16'd0;
                sel_nxt    = SLOT_W'(f_slot);
                state_nxt  = S_ALLOC;
              end else begin
                res_stat_nxt = STAT_NOPORT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LOOK: begin
        if (exit_tok.vld) begin
          res_stat_nxt = exit_tok.match ? STAT_OK : STAT_MISS;
          res_hit_nxt  = exit_tok.match ? 4'(exit_tok.idx) : 4'd0;
          state_nxt    = S_RESP;
        end
      end
      S_ALLOC: begin
        if (issued_r < tries) begin
          issue_tok.vld   = 1'b1;
          issue_tok.dport = cand_c;
          cand_nxt        = port_succ(cand_c, dyn_first_r, dyn_limit_r);
          issued_nxt      = issued_r + 16'd1;
        end
        if (exit_tok.vld) begin
          ret_nxt = ret_r + 16'd1;
          if (!exit_tok.match) begin
            // free port found: claim it and drop probes still in flight
            wr.pwe        = 1'b1;
            wr.sel        = sel_r;
            wr.lport      = exit_tok.dport;
            res_stat_nxt  = STAT_OK;
            res_port_nxt  = exit_tok.dport;
            next_port_nxt = port_succ(exit_tok.dport, dyn_first_r, dyn_limit_r);
            kill          = 1'b1;
            state_nxt     = S_RESP;
          end else if ((ret_r + 16'd1) == tries) begin
            res_stat_nxt  = STAT_NOPORT;
            next_port_nxt = cand_r;
            state_nxt     = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = res_stat_r;
          out_hit_nxt   = res_hit_r;
          out_port_nxt  = res_port_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      next_port_r <= DYN_FIRST_RST;
      out_valid_r <= 1'b0;
      issued_r    <= 16'd0;
      ret_r       <= 16'd0;
    end else begin
      state_r     <= state_nxt;
      next_port_r <= next_port_nxt;
      out_valid_r <= out_valid_nxt;
      issued_r    <= issued_nxt;
      ret_r       <= ret_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r     <= cand_nxt;
    sel_r      <= sel_nxt;
    res_stat_r <= res_stat_nxt;
    res_hit_r  <= res_hit_nxt;
    res_port_r <= res_port_nxt;
    out_stat_r <= out_stat_nxt;
    out_hit_r  <= out_hit_nxt;
    out_port_r <= out_port_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_stat_r;
  assign out_tdata  = {4'd0, out_port_r, out_hit_r};

endmodule

// ----- design/udst_checker.sv -----
// Port-level checks for the UDP socket demux table, bound to the top level
`include "udp_socket_demux_table_defines.svh"

module udst_checker
  import udst_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser
);

  `UDST_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")
  `UDST_ASSERT(a_stat_code, out_tvalid |-> (out_tuser == STAT_OK) || (out_tuser == STAT_MISS) || (out_tuser == STAT_NOPORT), "undefined status")
  `UDST_ASSERT(a_fail_zero, out_tvalid && (out_tuser != STAT_OK) |-> out_tdata == 24'd0, "failed request carries data")
  `UDST_ASSERT(a_hit_or_port, out_tvalid |-> (out_tdata[3:0] == 4'd0) || (out_tdata[19:4] == 16'd0), "hit slot and port both set")
  `UDST_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind udp_socket_demux_table udst_checker u_udst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
